>>> rtl/c3lb_pkg.sv
// Shared constants, types and register codes of the 3x3 line buffer filter.
package c3lb_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);

    localparam int KSIZE       = 3;
    localparam int CELLS       = KSIZE * KSIZE;
    localparam int FIRST_FULL  = KSIZE - 1;
    localparam int MIN_DIM     = 3;

    localparam int WCFG_W      = 11;
    localparam int HCFG_W      = 13;
    localparam int PIX_W       = 16;
    localparam int COEF_W      = 16;
    localparam int KROW_W      = COEF_W * KSIZE;
    localparam int PROD_W      = PIX_W + COEF_W;
    localparam int ROWSUM_W    = PROD_W + 2;
    localparam int TOTAL_W     = ROWSUM_W + 2;
    localparam int FRAC_SHIFT  = 14;

    localparam int APB_DW      = 64;
    localparam int APB_AW      = 6;
    localparam int REG_LSB     = 3;
    localparam int REG_IDX_W   = APB_AW - REG_LSB;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(1024);
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(1024);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_KERNEL_TOP,
        REG_KERNEL_MIDDLE,
        REG_KERNEL_BOTTOM
    } t_reg_idx;

    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic shift;    // a real pixel moves into the window
        logic adv;      // whole pipeline steps
    } t_cell_ctrl;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

endpackage

>>> rtl/c3lb_line_buf.sv
// Two line buffers holding the previous two rows, registered read.
module c3lb_line_buf
    import c3lb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [COL_W-1:0]        i_rd_addr,
    input  logic                    i_wr_en,
    input  logic [COL_W-1:0]        i_wr_addr,
    input  logic [PIX_W-1:0]        i_pix,
    output logic [PIX_W-1:0]        o_older,
    output logic [PIX_W-1:0]        o_newer
);

    logic [PIX_W-1:0] r_older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_older;
    logic [PIX_W-1:0] r_rd_newer;

    // write-back uses the read data of the same pixel: the newer row ages
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_older_mem[i_wr_addr] <= r_rd_newer;
            r_newer_mem[i_wr_addr] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_older <= r_older_mem[i_rd_addr];
            r_rd_newer <= r_newer_mem[i_rd_addr];
        end
    end

    assign o_older = r_rd_older;
    assign o_newer = r_rd_newer;

endmodule

>>> rtl/c3lb_tap_cell.sv
// One window tap: holds a pixel, passes it left, multiplies by its coefficient.
module c3lb_tap_cell
    import c3lb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [PIX_W-1:0]  i_pix,
    input  logic signed [COEF_W-1:0] i_coef,
    output logic signed [PIX_W-1:0]  o_pix,
    output t_prod                    o_prod
);

    logic signed [PIX_W-1:0] r_pix;
    t_prod                   r_prod;
    t_prod                   n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_ctrl.shift) begin
            r_pix <= i_pix;
        end
    end

    assign n_prod = r_pix * i_coef;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_prod <= n_prod;
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

>>> rtl/c3lb_adder_tree.sv
// Registered sum of the nine tap products, rounding and saturation to Q8.8.
module c3lb_adder_tree
    import c3lb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_adv,
    input  t_prod                   i_prod [CELLS],
    output logic signed [PIX_W-1:0] o_filtered
);

    localparam logic signed [TOTAL_W-1:0] ROUND_BIAS = TOTAL_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [TOTAL_W-1:0] SAT_MAX    = TOTAL_W'((1 <<< (PIX_W - 1)) - 1);
    localparam logic signed [TOTAL_W-1:0] SAT_MIN    = -(TOTAL_W'(1) <<< (PIX_W - 1));

    logic signed [ROWSUM_W-1:0] r_rowsum [KSIZE];
    logic signed [TOTAL_W-1:0]  r_total;
    logic signed [TOTAL_W-1:0]  shifted;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int a = 0; a < KSIZE; a++) begin
                r_rowsum[a] <= ROWSUM_W'(i_prod[a*KSIZE])
                             + ROWSUM_W'(i_prod[a*KSIZE+1])
                             + ROWSUM_W'(i_prod[a*KSIZE+2]);
            end
            r_total <= TOTAL_W'(r_rowsum[0]) + TOTAL_W'(r_rowsum[1])
                     + TOTAL_W'(r_rowsum[2]) + ROUND_BIAS;
        end
    end

    // bias already added: arithmetic shift gives round-half-up
    always_comb begin
        shifted = r_total >>> FRAC_SHIFT;
        if (shifted > SAT_MAX) begin
            o_filtered = SAT_MAX[PIX_W-1:0];
        end else if (shifted < SAT_MIN) begin
            o_filtered = SAT_MIN[PIX_W-1:0];
        end else begin
            o_filtered = shifted[PIX_W-1:0];
        end
    end

endmodule

>>> rtl/conv3x3_line_buffer_filter.sv
// Top level: 3x3 correlation filter over a raster pixel stream.
//
//  channel   direction  handshake                 payload
//  pixel in  input      i_in_valid / o_in_ready   i_pixel
//  result    output     o_out_valid / i_out_ready o_filtered, o_out_row, o_out_col,
//                                                 o_last_of_frame
//  config    input      APB psel/penable/pready   paddr, pwdata, prdata
//
// Sustains one pixel per clock while no held result stalls it. A result reaches
// the output register through line buffer read, window tap, multiply, row sums,
// total and round/saturate, in that order.
// Synchronous reset clears control, counters and window; line buffers are not
// cleared (no clearing pass).
// A held result stalls the whole pipeline; input is taken whenever it moves.
module conv3x3_line_buffer_filter
    import c3lb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [PIX_W-1:0] i_pixel,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [PIX_W-1:0] o_filtered,
    output logic [ROW_W-1:0]        o_out_row,
    output logic [COL_W-1:0]        o_out_col,
    output logic                    o_last_of_frame,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    localparam int STAGES = 5;

    // configuration
    logic [WCFG_W-1:0] r_image_width;
    logic [HCFG_W-1:0] r_image_height;
    logic [KROW_W-1:0] r_kernel [KSIZE];
    t_reg_idx          reg_idx;

    // control
    logic              adv;
    logic              accept;
    logic [WCFG_W-1:0] w_eff;
    logic [HCFG_W-1:0] h_eff;
    logic [WCFG_W-1:0] col_next;
    logic [HCFG_W-1:0] row_next;
    logic              emit;
    t_meta             meta_in;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    // pipeline
    logic                    r_v0;
    logic [PIX_W-1:0]        r_px0;
    logic [COL_W-1:0]        r_col0;
    logic [STAGES-1:0]       r_res;
    t_meta                   r_pay [STAGES];
    t_cell_ctrl              cell_ctrl;
    logic [PIX_W-1:0]        lb_older;
    logic [PIX_W-1:0]        lb_newer;
    logic signed [PIX_W-1:0] src [KSIZE];
    logic signed [PIX_W-1:0] cell_pix [CELLS];
    t_prod                   cell_prod [CELLS];
    logic signed [PIX_W-1:0] tree_filtered;

    logic                    r_out_valid;
    logic signed [PIX_W-1:0] r_out_filtered;
    t_meta                   r_out_meta;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:REG_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            for (int k = 0; k < KSIZE; k++) begin
                r_kernel[k] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:   r_image_width  <= pwdata[WCFG_W-1:0];
                REG_IMAGE_HEIGHT:  r_image_height <= pwdata[HCFG_W-1:0];
                REG_KERNEL_TOP:    r_kernel[0]    <= pwdata[KROW_W-1:0];
                REG_KERNEL_MIDDLE: r_kernel[1]    <= pwdata[KROW_W-1:0];
                REG_KERNEL_BOTTOM: r_kernel[2]    <= pwdata[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:   prdata = APB_DW'(r_image_width);
            REG_IMAGE_HEIGHT:  prdata = APB_DW'(r_image_height);
            REG_KERNEL_TOP:    prdata = APB_DW'(r_kernel[0]);
            REG_KERNEL_MIDDLE: prdata = APB_DW'(r_kernel[1]);
            REG_KERNEL_BOTTOM: prdata = APB_DW'(r_kernel[2]);
            default:           prdata = '0;
        endcase
    end

    // ---------------- frame position ----------------
    always_comb begin
        if (r_image_width < WCFG_W'(MIN_DIM)) begin
            w_eff = WCFG_W'(MIN_DIM);
        end else if (r_image_width > WCFG_W'(MAX_WIDTH)) begin
            w_eff = WCFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height < HCFG_W'(MIN_DIM)) begin
            h_eff = HCFG_W'(MIN_DIM);
        end else if (r_image_height > HCFG_W'(MAX_HEIGHT)) begin
            h_eff = HCFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_image_height;
        end
    end

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    assign col_next = WCFG_W'(r_col) + WCFG_W'(1);
    assign row_next = HCFG_W'(r_row) + HCFG_W'(1);

    assign emit = (r_row >= ROW_W'(FIRST_FULL)) && (r_col >= COL_W'(FIRST_FULL))
               && (HCFG_W'(r_row) < h_eff) && (WCFG_W'(r_col) < w_eff);

    assign meta_in.row  = r_row - ROW_W'(1);
    assign meta_in.col  = r_col - COL_W'(1);
    assign meta_in.last = (HCFG_W'(r_row) == h_eff - HCFG_W'(1))
                       && (WCFG_W'(r_col) == w_eff - WCFG_W'(1));

    // a counter past a shrunken limit wraps like the end of a row/frame
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_next >= w_eff) begin
            n_col = '0;
            n_row = (row_next >= h_eff) ? '0 : row_next[ROW_W-1:0];
        end else begin
            n_col = col_next[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- pipeline control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_res <= '0;
        end else if (adv) begin
            r_v0     <= accept;
            r_res[0] <= accept && emit;
            for (int k = 1; k < STAGES; k++) begin
                r_res[k] <= r_res[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (accept) begin
                r_px0    <= i_pixel;
                r_col0   <= r_col;
                r_pay[0] <= meta_in;
            end
            for (int k = 1; k < STAGES; k++) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    // ---------------- line buffers ----------------
    c3lb_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .i_wr_en   (r_v0 && adv),
        .i_wr_addr (r_col0),
        .i_pix     (r_px0),
        .o_older   (lb_older),
        .o_newer   (lb_newer)
    );

    // ---------------- window cells ----------------
    assign cell_ctrl.shift = r_v0 && adv;
    assign cell_ctrl.adv   = adv;

    assign src[0] = lb_older;
    assign src[1] = lb_newer;
    assign src[2] = r_px0;

    for (genvar a = 0; a < KSIZE; a++) begin : g_row
        for (genvar b = 0; b < KSIZE; b++) begin : g_col
            logic signed [PIX_W-1:0] tap_in;
            if (b == KSIZE - 1) begin : g_src
                assign tap_in = src[a];
            end else begin : g_chain
                assign tap_in = cell_pix[a*KSIZE+b+1];
            end

            c3lb_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (cell_ctrl),
                .i_pix   (tap_in),
                .i_coef  (r_kernel[a][COEF_W*b +: COEF_W]),
                .o_pix   (cell_pix[a*KSIZE+b]),
                .o_prod  (cell_prod[a*KSIZE+b])
            );
        end
    end

    c3lb_adder_tree u_adder_tree (
        .i_clk      (i_clk),
        .i_adv      (adv),
        .i_prod     (cell_prod),
        .o_filtered (tree_filtered)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_res[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_res[STAGES-1]) begin
            r_out_filtered <= tree_filtered;
            r_out_meta     <= r_pay[STAGES-1];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_filtered      = r_out_filtered;
    assign o_out_row       = r_out_meta.row;
    assign o_out_col       = r_out_meta.col;
    assign o_last_of_frame = r_out_meta.last;

    // ---------------- assertions ----------------
    a_lb_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_v0 && adv) |-> (r_col != r_col0))
        else $error("line buffer read and write hit the same column");

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_col == '0) || (r_col == $past(r_col) + COL_W'(1)))
        else $error("column counter skipped");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res[1] |-> (r_pay[1].row != '0) && (r_pay[1].col != '0))
        else $error("result tagged with a border position");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_res[STAGES-1]))
        else $error("output valid without a pipeline result");

endmodule
